/* rtl/bse_pkg.sv */
// Shared types and constants for the byte entropy block.
// No dependencies; bse_if, bse_core and the top level use this package.
`timescale 1ns / 1ps
`default_nettype none
package bse_pkg;

  localparam int CNT_W     = 32;        // histogram bin and total width
  localparam int FRAC_BITS = 16;        // fraction bits of the entropy result
  localparam int BINS      = 256;
  localparam int BIN_W     = 8;
  localparam int ENT_W     = 20;        // entropy result width
  localparam int TOT_W     = 32;        // byte total result width
  localparam int EXP_W     = 5;         // integer part of log2 of a count
  localparam int LOG_W     = EXP_W + 32; // log2 in Q32
  localparam int D_W       = 30;        // log2(N/c) in Q24
  localparam int Q_W       = 33;        // c/N in Q32, up to 1.0
  localparam int PROD_W    = Q_W + D_W;
  localparam int ACC_W     = 60;        // Q56 sum, clamped at 8.0
  localparam int IT_W      = 5;         // 32 squaring / divide steps

  localparam logic [CNT_W-1:0] CNT_MAX   = '1;
  localparam logic [ACC_W-1:0] EIGHT_ACC = ACC_W'(8) << 56;
  localparam logic [ACC_W-1:0] ACC_RND   = ACC_W'(1) << (55 - FRAC_BITS);
  localparam logic [ENT_W-1:0] EIGHT_ENT = ENT_W'(8) << FRAC_BITS;

  // Control from the top level to the entropy sequencer
  typedef struct packed {
    logic start;
    logic ack;
  } core_ctl_t;

  // Status from the entropy sequencer
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [ENT_W-1:0] entropy;
  } core_sts_t;

endpackage
`default_nettype wire

/* rtl/bse_if.sv */
// Valid/ready channel interfaces for the byte entropy block.
// Depends on bse_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface bse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       last;

  modport source (output valid, data_byte, byte_valid, last, input ready);
  modport sink   (input valid, data_byte, byte_valid, last, output ready);
endinterface

interface bse_out_if;
  logic                      valid;
  logic                      ready;
  logic [bse_pkg::ENT_W-1:0] entropy_bits;
  logic [bse_pkg::TOT_W-1:0] byte_total;
  logic                      count_overflow;

  modport source (output valid, entropy_bits, byte_total, count_overflow, input ready);
  modport sink   (input valid, entropy_bits, byte_total, count_overflow, output ready);
endinterface
`default_nettype wire

/* rtl/bse_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module bse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/bse_core.sv */
// Entropy sequencer: sweeps the histogram and computes the entropy with one
// shared multiplier and a shift/subtract step. Depends on bse_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bse_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire bse_pkg::core_ctl_t           ctl,
  output bse_pkg::core_sts_t                sts,
  input  wire logic [bse_pkg::CNT_W-1:0]    n,
  output logic      [bse_pkg::BIN_W-1:0]    rd_addr,
  input  wire logic [bse_pkg::CNT_W-1:0]    rd_data
);

  typedef enum logic [3:0] {
    C_IDLE, C_NORM, C_SQR, C_DIFF, C_DIV, C_MUL, C_ACC, C_RD, C_WAIT, C_FIN, C_DONE
  } cst_t;

  cst_t                         st_r, st_nxt;
  logic [bse_pkg::CNT_W-1:0]    n_r, n_nxt;
  logic [bse_pkg::LOG_W-1:0]    ln_r, ln_nxt;
  logic [31:0]                  x_r, x_nxt;
  logic [bse_pkg::EXP_W-1:0]    e_r, e_nxt;
  logic [31:0]                  frac_r, frac_nxt;
  logic [bse_pkg::IT_W-1:0]     it_r, it_nxt;
  logic                         is_n_r, is_n_nxt;
  logic [bse_pkg::BIN_W-1:0]    bin_r, bin_nxt;
  logic [bse_pkg::CNT_W-1:0]    c_r, c_nxt;
  logic [bse_pkg::D_W-1:0]      d_r, d_nxt;
  logic [bse_pkg::Q_W-1:0]      q_r, q_nxt;
  logic [31:0]                  r_r, r_nxt;
  logic [bse_pkg::PROD_W-1:0]   prod_r, prod_nxt;
  logic [bse_pkg::ACC_W-1:0]    acc_r, acc_nxt;
  logic [bse_pkg::ENT_W-1:0]    ent_r, ent_nxt;

  // shared multiplier: squaring during log2, c/N times log2(N/c) afterwards
  logic [32:0] mul_a;
  logic [31:0] mul_b;
  logic [64:0] mul_p;
  logic [32:0] sq_t;
  logic [bse_pkg::LOG_W-1:0] lc, diff;
  logic [bse_pkg::LOG_W:0]   d_sum;
  logic [32:0] r2;
  logic [63:0] acc_sum;
  logic [bse_pkg::ACC_W-1:0] rnd_sum;

  assign mul_a = (st_r == C_SQR) ? {1'b0, x_r} : q_r;
  assign mul_b = (st_r == C_SQR) ? x_r
                                 : {{(32 - bse_pkg::D_W){1'b0}}, d_r};
  assign mul_p = mul_a * mul_b;
  assign sq_t  = mul_p[63:31];

  assign lc    = {e_r, frac_r};
  assign diff  = (ln_r > lc) ? (ln_r - lc) : '0;
  assign d_sum = {1'b0, diff} + (bse_pkg::LOG_W + 1)'(128);

  assign r2      = {r_r, 1'b0};
  assign acc_sum = {4'b0, acc_r} + {1'b0, prod_r};
  assign rnd_sum = acc_r + bse_pkg::ACC_RND;

  // next-state and datapath
  always_comb begin
    st_nxt   = st_r;
    n_nxt    = n_r;
    ln_nxt   = ln_r;
    x_nxt    = x_r;
    e_nxt    = e_r;
    frac_nxt = frac_r;
    it_nxt   = it_r;
    is_n_nxt = is_n_r;
    bin_nxt  = bin_r;
    c_nxt    = c_r;
    d_nxt    = d_r;
    q_nxt    = q_r;
    r_nxt    = r_r;
    prod_nxt = prod_r;
    acc_nxt  = acc_r;
    ent_nxt  = ent_r;
    case (st_r)
      C_IDLE: begin
        if (ctl.start) begin
          n_nxt   = n;
          acc_nxt = '0;
          bin_nxt = '0;
          if (n == '0) begin
            st_nxt = C_FIN;
          end else begin
            x_nxt    = n;
            e_nxt    = '1;
            is_n_nxt = 1'b1;
            st_nxt   = C_NORM;
          end
        end
      end
      // normalize to a Q31 mantissa, one bit a cycle
      C_NORM: begin
        if (x_r[31]) begin
          it_nxt = '0;
          st_nxt = C_SQR;
        end else begin
          x_nxt = {x_r[30:0], 1'b0};
          e_nxt = e_r - 1'b1;
        end
      end
      // one fraction bit per squaring
      C_SQR: begin
        if (sq_t[32]) begin
          x_nxt    = sq_t[32:1];
          frac_nxt = {frac_r[30:0], 1'b1};
        end else begin
          x_nxt    = sq_t[31:0];
          frac_nxt = {frac_r[30:0], 1'b0};
        end
        it_nxt = it_r + 1'b1;
        if (it_r == '1) begin
          if (is_n_r) begin
            ln_nxt = {e_r, frac_nxt};
            st_nxt = C_RD;
          end else begin
            st_nxt = C_DIFF;
          end
        end
      end
      C_DIFF: begin
        d_nxt = d_sum[bse_pkg::LOG_W -: bse_pkg::D_W];
        if (c_r >= n_r) begin
          q_nxt  = bse_pkg::Q_W'(1) << 32;
          st_nxt = C_MUL;
        end else begin
          q_nxt  = '0;
          r_nxt  = c_r;
          it_nxt = '0;
          st_nxt = C_DIV;
        end
      end
      // restoring division, one quotient bit a cycle
      C_DIV: begin
        if (r2 >= {1'b0, n_r}) begin
          r_nxt = 32'(r2 - {1'b0, n_r});
          q_nxt = {q_r[bse_pkg::Q_W-2:0], 1'b1};
        end else begin
          r_nxt = r2[31:0];
          q_nxt = {q_r[bse_pkg::Q_W-2:0], 1'b0};
        end
        it_nxt = it_r + 1'b1;
        if (it_r == '1) begin
          st_nxt = C_MUL;
        end
      end
      C_MUL: begin
        prod_nxt = mul_p[bse_pkg::PROD_W-1:0];
        st_nxt   = C_ACC;
      end
      C_ACC: begin
        acc_nxt = (acc_sum > {4'b0, bse_pkg::EIGHT_ACC}) ? bse_pkg::EIGHT_ACC
                                                         : acc_sum[bse_pkg::ACC_W-1:0];
        bin_nxt = bin_r + 1'b1;
        st_nxt  = (bin_r == '1) ? C_FIN : C_RD;
      end
      C_RD: begin
        st_nxt = C_WAIT;
      end
      // bin count arrives from the RAM; empty bins are skipped
      C_WAIT: begin
        if (rd_data == '0) begin
          bin_nxt = bin_r + 1'b1;
          st_nxt  = (bin_r == '1) ? C_FIN : C_RD;
        end else begin
          c_nxt    = rd_data;
          x_nxt    = rd_data;
          e_nxt    = '1;
          frac_nxt = '0;
          is_n_nxt = 1'b0;
          st_nxt   = C_NORM;
        end
      end
      C_FIN: begin
        ent_nxt = (rnd_sum[bse_pkg::ACC_W-1 -: bse_pkg::ENT_W] > bse_pkg::EIGHT_ENT)
                  ? bse_pkg::EIGHT_ENT : rnd_sum[bse_pkg::ACC_W-1 -: bse_pkg::ENT_W];
        st_nxt  = C_DONE;
      end
      C_DONE: begin
        if (ctl.ack) begin
          st_nxt = C_IDLE;
        end
      end
      default: st_nxt = C_IDLE;
    endcase
  end

  // state and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= C_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    n_r    <= n_nxt;
    ln_r   <= ln_nxt;
    x_r    <= x_nxt;
    e_r    <= e_nxt;
    frac_r <= frac_nxt;
    it_r   <= it_nxt;
    is_n_r <= is_n_nxt;
    bin_r  <= bin_nxt;
    c_r    <= c_nxt;
    d_r    <= d_nxt;
    q_r    <= q_nxt;
    r_r    <= r_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    ent_r  <= ent_nxt;
  end

  assign rd_addr     = bin_r;
  assign sts.busy    = (st_r != C_IDLE);
  assign sts.done    = (st_r == C_DONE);
  assign sts.entropy = ent_r;

endmodule
`default_nettype wire

/* rtl/byte_shannon_entropy_top.sv */
// Top level of the byte entropy block: byte histogram in RAM, update path
// and output register. Depends on bse_pkg, bse_if, bse_ram and bse_core.
//
// Usage:
//   in_if  (sink): one transaction carries data_byte, byte_valid and last.
//     byte_valid counts data_byte into its bin and the total; last closes
//     the stream and starts the entropy pass once that byte is counted.
//   out_if (source): one transaction per stream with entropy_bits
//     (16 fraction bits), byte_total and count_overflow.
// Input: each transaction is a bin read, then a bin write through the single
//   RAM write port; in_if.ready is low meanwhile, so a byte is not taken
//   before the previous one is written.
// Entropy pass after last: normalize shifts, 32-step log2 squaring and
//   32-step division on the shared multiplier and subtractor for every
//   non-empty bin; empty bins are skipped.
// Reset: clears the bin valid bits, total, overflow flag and output valid;
//   the histogram RAM itself needs no clearing pass. The valid bits, total
//   and overflow flag are also cleared after each result.
// Stall: a result waits in the output register while out_if.ready is low;
//   new bytes are still taken, and a second result waits in the sequencer.
`timescale 1ns / 1ps
`default_nettype none
module byte_shannon_entropy_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bse_in_if.sink     in_if,
  bse_out_if.source  out_if
);

  typedef enum logic [1:0] {ST_IDLE, ST_UPD, ST_CALC} st_t;

  st_t                          st_r;
  logic [bse_pkg::BINS-1:0]     vld_r;
  logic                         vld_q_r;
  logic [bse_pkg::BIN_W-1:0]    byte_r;
  logic                         bval_r;
  logic                         last_r;
  logic [bse_pkg::CNT_W-1:0]    total_r;
  logic                         ovf_r;
  logic                         out_vld_r;
  logic [bse_pkg::ENT_W-1:0]    out_ent_r;
  logic [bse_pkg::TOT_W-1:0]    out_tot_r;
  logic                         out_ovf_r;

  logic                         in_acc;
  logic [bse_pkg::BIN_W-1:0]    raddr;
  logic [bse_pkg::BIN_W-1:0]    core_addr;
  logic [bse_pkg::CNT_W-1:0]    ram_rdata;
  logic [bse_pkg::CNT_W-1:0]    bin_cnt;
  logic                         ram_we;
  logic                         res_load;
  bse_pkg::core_ctl_t           core_ctl;
  bse_pkg::core_sts_t           core_sts;

  assign in_if.ready = (st_r == ST_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign raddr       = (st_r == ST_IDLE) ? in_if.data_byte : core_addr;
  assign bin_cnt     = vld_q_r ? ram_rdata : '0;
  assign ram_we      = (st_r == ST_UPD) && bval_r && (bin_cnt != bse_pkg::CNT_MAX);
  assign res_load    = (st_r == ST_CALC) && core_sts.done && (!out_vld_r || out_if.ready);

  assign core_ctl.start = (st_r == ST_UPD) && last_r;
  assign core_ctl.ack   = res_load;

  bse_ram #(.WIDTH(bse_pkg::CNT_W), .DEPTH(bse_pkg::BINS)) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (byte_r),
    .wdata (bin_cnt + 1'b1),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  bse_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (core_ctl),
    .sts     (core_sts),
    .n       (total_r),
    .rd_addr (core_addr),
    .rd_data (bin_cnt)
  );

  // valid bit follows the registered RAM read
  always_ff @(posedge clk) begin
    vld_q_r <= vld_r[raddr];
  end

  // update sequencer, counters and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      vld_r     <= '0;
      total_r   <= '0;
      ovf_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (out_if.ready && !res_load) begin
        out_vld_r <= 1'b0;
      end
      case (st_r)
        ST_IDLE: begin
          if (in_acc) begin
            byte_r <= in_if.data_byte;
            bval_r <= in_if.byte_valid;
            last_r <= in_if.last;
            if (in_if.byte_valid) begin
              if (total_r == bse_pkg::CNT_MAX) begin
                ovf_r <= 1'b1;
              end else begin
                total_r <= total_r + 1'b1;
              end
            end
            st_r <= ST_UPD;
          end
        end
        ST_UPD: begin
          if (bval_r) begin
            if (bin_cnt == bse_pkg::CNT_MAX) begin
              ovf_r <= 1'b1;
            end else begin
              vld_r[byte_r] <= 1'b1;
            end
          end
          st_r <= last_r ? ST_CALC : ST_IDLE;
        end
        ST_CALC: begin
          if (res_load) begin
            out_vld_r <= 1'b1;
            out_ent_r <= core_sts.entropy;
            out_tot_r <= total_r;
            out_ovf_r <= ovf_r;
            vld_r     <= '0;
            total_r   <= '0;
            ovf_r     <= 1'b0;
            st_r      <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign out_if.valid          = out_vld_r;
  assign out_if.entropy_bits   = out_ent_r;
  assign out_if.byte_total     = out_tot_r;
  assign out_if.count_overflow = out_ovf_r;

  // the sequencer only runs while input is held off
  a_busy_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    core_sts.busy |-> !in_if.ready)
    else $error("input accepted during entropy pass");

  // counters are cleared when a result is loaded
  a_clear_after_res: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> (total_r == '0) && !ovf_r && (vld_r == '0))
    else $error("histogram state not cleared after result");

  // entropy never exceeds 8.0 bits per byte
  a_ent_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_ent_r <= bse_pkg::EIGHT_ENT))
    else $error("entropy above 8.0");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_if.ready) |-> !res_load)
    else $error("result overwritten while stalled");

endmodule
`default_nettype wire
